### src/evwa_pkg.sv
// Package for the event interval window average block.
// Holds the field widths, function and register codes, and the divider types.
// Used by evwa_div and event_interval_window_average_core.
`default_nettype none

package evwa_pkg;

	localparam int FUNC_W = 2;
	localparam int TIME_W = 32;
	localparam int TOTAL_W = 37;
	localparam int SLOT_W = 6;
	localparam int WLEN_W = 6;
	localparam int LEN_LIMIT = 63;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;

	localparam logic [FUNC_W-1:0] FUNC_TRIGGER = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_STOP = 2'd2;

	localparam logic CFG_STOP_WHEN_FULL = 1'b0;
	localparam logic CFG_WINDOW_LENGTH = 1'b1;

	typedef struct packed {
		logic [TOTAL_W-1:0] dividend;
		logic [SLOT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

### src/evwa_div.sv
// Bit-serial restoring divider for the interval total over the interval count.
// One quotient bit per cycle; the quotient saturates to 32 bits.
// Depends on evwa_pkg.
`default_nettype none

module evwa_div
	import evwa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire div_req_t          req,
	output div_stat_t              stat,
	output logic [TIME_W-1:0]      quotient
);

	localparam logic [5:0] STEPS = 6'(TOTAL_W);

	logic [TOTAL_W-1:0] work_q;
	logic [SLOT_W-1:0] rem_q;
	logic [SLOT_W-1:0] divisor_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [SLOT_W:0] partial;
	logic [SLOT_W:0] trial;
	logic ge;

	assign partial = {rem_q, work_q[TOTAL_W-1]};
	assign trial = partial - {1'b0, divisor_q};
	assign ge = partial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= req.dividend;
			divisor_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[TOTAL_W-2:0], ge};
			rem_q <= ge ? trial[SLOT_W-1:0] : partial[SLOT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = (|work_q[TOTAL_W-1:TIME_W]) ? '1 : work_q[TIME_W-1:0];

endmodule

`default_nettype wire

### src/event_interval_window_average_core.sv
// Event interval window average: ring of trigger intervals with a running average.
// A recording trigger goes through read, subtract, add, 37 divider steps and output before
// the next item is taken: no new item is taken while one is in work.
// Other items go from accept straight to the output state.
// A result the sink has not taken holds off the next item. Reset clears control state and
// totals; the interval memory is not cleared.
`default_nettype none

module event_interval_window_average_core
	import evwa_pkg::*;
#(
	parameter int MAX_INTERVALS = 32
)
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// Bits from low: start_if_idle[0], now[32:1], zero fill [39:33].
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// Bits from low: func[1:0].
	input  wire logic [S_TUSER_W-1:0] s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// Bits from low: done_res[0], recording[1], average_interval[33:2],
	// intervals_recorded[39:34].
	output logic [M_TDATA_W-1:0]      m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_index,
	input  wire logic [WLEN_W-1:0]    cfg_data
);

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int LEN_CAP = (MAX_INTERVALS < LEN_LIMIT) ? MAX_INTERVALS : LEN_LIMIT;
	localparam logic [SLOT_W-1:0] LEN_CAP_V = SLOT_W'(LEN_CAP);
	localparam logic IDX_ALWAYS_FITS = (MAX_INTERVALS > LEN_LIMIT);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUB = 3'd1;
	localparam logic [2:0] ST_ADD = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic stop_when_full_q;
	logic [WLEN_W-1:0] window_length_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TIME_W-1:0] last_q;
	logic wrapped_q;
	logic active_q;
	logic [TIME_W-1:0] avg_q;
	logic done_q;
	logic [SLOT_W-1:0] idx_q;
	logic [TIME_W-1:0] iv_q;
	logic [TIME_W-1:0] rd_q;
	logic [TIME_W-1:0] store_q [MAX_INTERVALS];
	logic m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;

	logic [FUNC_W-1:0] func;
	logic start_if_idle;
	logic [TIME_W-1:0] now;
	logic [SLOT_W-1:0] len;
	logic [SLOT_W-1:0] idx;
	logic [SLOT_W-1:0] next_slot;
	logic [SLOT_W-1:0] count;
	logic accept;
	logic rd_en;
	logic wr_en;
	logic div_start;
	div_req_t div_req;
	div_stat_t div_stat;
	logic [TIME_W-1:0] div_quot;

	assign func = s_tuser[FUNC_W-1:0];
	assign start_if_idle = s_tdata[0];
	assign now = s_tdata[TIME_W:1];

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (window_length_q == '0) begin
			len = SLOT_W'(1);
		end else if (window_length_q > LEN_CAP_V) begin
			len = LEN_CAP_V;
		end else begin
			len = window_length_q;
		end
	end

	assign idx = (IDX_ALWAYS_FITS || (slot_q < LEN_CAP_V)) ? slot_q : '0;
	assign next_slot = idx_q + SLOT_W'(1);
	assign count = wrapped_q ? len : slot_q;

	assign rd_en = accept && (func == FUNC_TRIGGER) && active_q;
	assign wr_en = (state_q == ST_SUB);
	assign div_start = (state_q == ST_ADD);
	assign div_req.dividend = total_q + {{(TOTAL_W-TIME_W){1'b0}}, iv_q};
	assign div_req.divisor = wrapped_q ? len : next_slot;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= store_q[AW'(idx)];
		end
		if (wr_en) begin
			store_q[AW'(idx_q)] <= iv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_when_full_q <= 1'b0;
			window_length_q <= WLEN_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_STOP_WHEN_FULL: stop_when_full_q <= cfg_data[0];
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			slot_q <= '0;
			last_q <= '0;
			wrapped_q <= 1'b0;
			active_q <= 1'b0;
			avg_q <= '0;
			done_q <= 1'b0;
			idx_q <= '0;
			iv_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						done_q <= (func == FUNC_TRIGGER) && !active_q && !start_if_idle;
						state_q <= rd_en ? ST_SUB : ST_OUT;
						case (func)
							FUNC_TRIGGER: begin
								if (active_q) begin
									idx_q <= idx;
									iv_q <= now - last_q;
									last_q <= now;
								end else if (start_if_idle) begin
									avg_q <= '0;
									slot_q <= '0;
									total_q <= '0;
									wrapped_q <= 1'b0;
									active_q <= 1'b1;
									last_q <= now;
								end
							end
							FUNC_START: begin
								avg_q <= '0;
								slot_q <= '0;
								total_q <= '0;
								wrapped_q <= 1'b0;
								active_q <= 1'b1;
								last_q <= now;
							end
							FUNC_STOP: begin
								active_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_SUB: begin
					total_q <= total_q - (wrapped_q ? {{(TOTAL_W-TIME_W){1'b0}}, rd_q} : '0);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					total_q <= div_req.dividend;
					if ((next_slot >= len) && !stop_when_full_q) begin
						slot_q <= '0;
						wrapped_q <= 1'b1;
					end else begin
						slot_q <= next_slot;
					end
					if ((next_slot >= len) && stop_when_full_q) begin
						active_q <= 1'b0;
						done_q <= 1'b1;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						avg_q <= div_quot;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!m_valid_q || m_tready)) begin
			m_data_q <= {count, avg_q, active_q, done_q};
		end
	end

	evwa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an item is in work");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside the divide state");

	a_div_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && div_stat.done) |=> (state_q == ST_OUT))
		else $error("divider result not taken");

	a_mem_order: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> wr_en)
		else $error("interval write does not follow its read");

endmodule

`default_nettype wire
